@@ rtl/adp_pkg.sv @@
package adp_pkg;

	// word and field widths
	localparam int DATA_W    = 32;
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_DECAY   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_EPSILON = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_START0  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_START1  = 2'd3;

	// operation codes
	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] DECAY_RST = 16'd62259;
	localparam logic [CFG_W-1:0] EPS_RST   = 16'd1;

	// saturation limits
	localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] NEG_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MAG_LIM = 32'h8000_0000;

endpackage

@@ rtl/adp_in_if.sv @@
interface adp_in_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic                                param_index;
	logic signed [adp_pkg::DATA_W-1:0]   gradient;

	modport source (output valid, output op, output param_index, output gradient, input ready);
	modport sink (input valid, input op, input param_index, input gradient, output ready);
endinterface

@@ rtl/adp_out_if.sv @@
interface adp_out_if;
	logic                                valid;
	logic                                ready;
	logic                                out_index;
	logic signed [adp_pkg::DATA_W-1:0]   param_value;
	logic signed [adp_pkg::DATA_W-1:0]   param_change;
	logic                                saturated;

	modport source (output valid, output out_index, output param_value, output param_change,
		output saturated, input ready);
	modport sink (input valid, input out_index, input param_value, input param_change,
		input saturated, output ready);
endinterface

@@ rtl/adadelta_param_update.sv @@
// Channel  | Dir | Words carried
// ---------+-----+--------------------------------------------------------
// in_ch    | in  | op, param_index, gradient (valid/ready)
// out_ch   | out | out_index, param_value, param_change, saturated
// cfg      | in  | cfg_wen, cfg_index, cfg_wdata (write only, no wait)
//
// An update word runs through the bit-serial divide and square root, which share one
// subtractor; restart and out-of-range words skip the arithmetic and go straight to
// the result. in_ch is ready again in the cycle after the result is loaded, and only
// while the sequencer is idle.
// A result that is not taken holds the sequencer until the output register frees.
// arst_n clears the sequencer, the output valid and the stores, and resets the config registers.
module adadelta_param_update #(
	parameter int NUM_PARAMS = 2,
	parameter int FRAC_BITS  = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [adp_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [adp_pkg::DATA_W-1:0]         cfg_wdata,
	adp_in_if.sink                             in_ch,
	adp_out_if.source                          out_ch
);

	localparam int DW = adp_pkg::DATA_W - 1 + FRAC_BITS;
	localparam int SW = (DW + 1) / 2;
	localparam int RW = 2 * SW;
	localparam int CW = $clog2(RW + 1);
	localparam int IW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
	localparam int PW = 2 * adp_pkg::DATA_W;
	localparam int XW = adp_pkg::DATA_W + 2;

	typedef enum logic [15:0] {
		S_IDLE   = 16'b0000_0000_0000_0001,
		S_GSQ    = 16'b0000_0000_0000_0010,
		S_EG_OLD = 16'b0000_0000_0000_0100,
		S_EG_NEW = 16'b0000_0000_0000_1000,
		S_EG_SUM = 16'b0000_0000_0001_0000,
		S_DEN    = 16'b0000_0000_0010_0000,
		S_DIV    = 16'b0000_0000_0100_0000,
		S_RATIO  = 16'b0000_0000_1000_0000,
		S_ROOT   = 16'b0000_0001_0000_0000,
		S_SCALE  = 16'b0000_0010_0000_0000,
		S_APPLY  = 16'b0000_0100_0000_0000,
		S_PARAM  = 16'b0000_1000_0000_0000,
		S_ED_OLD = 16'b0001_0000_0000_0000,
		S_ED_NEW = 16'b0010_0000_0000_0000,
		S_ED_SUM = 16'b0100_0000_0000_0000,
		S_DONE   = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [adp_pkg::CFG_W-1:0]  decay_q;
	logic [adp_pkg::CFG_W-1:0]  eps_q;
	logic [adp_pkg::DATA_W-1:0] sp0_q;
	logic [adp_pkg::DATA_W-1:0] sp1_q;

	// per-parameter state
	logic [adp_pkg::DATA_W-1:0] par_q   [NUM_PARAMS];
	logic [adp_pkg::DATA_W-1:0] avg_g_q [NUM_PARAMS];
	logic [adp_pkg::DATA_W-1:0] avg_c_q [NUM_PARAMS];

	// working registers
	logic                       idx_q;
	logic [adp_pkg::DATA_W-1:0] g_q;
	logic [adp_pkg::DATA_W-1:0] tmp_q;
	logic [PW-1:0]              acc_q;
	logic [PW-1:0]              mul_q;
	logic [adp_pkg::DATA_W-1:0] num_q;
	logic [adp_pkg::DATA_W-1:0] den_q;
	logic [adp_pkg::DATA_W-1:0] rem_q;
	logic [adp_pkg::DATA_W-1:0] q_q;
	logic                       ovf_q;
	logic [RW-1:0]              dsh_q;
	logic [CW-1:0]              cnt_q;
	logic [adp_pkg::DATA_W-1:0] val_q;
	logic [adp_pkg::DATA_W-1:0] chg_q;
	logic                       sat_q;

	// output register
	logic                       out_valid_q;
	logic                       out_index_q;
	logic [adp_pkg::DATA_W-1:0] out_val_q;
	logic [adp_pkg::DATA_W-1:0] out_chg_q;
	logic                       out_sat_q;

	logic                       in_acc;
	logic                       out_load;
	logic                       in_ok;
	logic [IW-1:0]              rd_idx;
	logic [adp_pkg::DATA_W-1:0] restart_val;
	logic [adp_pkg::DATA_W-1:0] gmag;
	logic [adp_pkg::DATA_W-1:0] w_old;
	logic [adp_pkg::DATA_W-1:0] w_new;
	logic [adp_pkg::DATA_W-1:0] mul_a;
	logic [adp_pkg::DATA_W-1:0] mul_b;
	logic [PW-1:0]              sq_sh;
	logic                       sq_ovf;
	logic [adp_pkg::DATA_W-1:0] sq_val;
	logic [PW-1:0]              avg_sum;
	logic [adp_pkg::DATA_W-1:0] avg_new;
	logic [adp_pkg::DATA_W:0]   num_sum;
	logic [adp_pkg::DATA_W:0]   den_sum;
	logic [XW-1:0]              sub_a;
	logic [XW-1:0]              sub_b;
	logic [XW:0]                sub_d;
	logic                       sub_ge;
	logic [adp_pkg::DATA_W-1:0] ratio;
	logic                       ratio_sat;
	logic [PW-1:0]              dm_sh;
	logic [adp_pkg::DATA_W-1:0] dmag;
	logic                       g_pos;
	logic [adp_pkg::DATA_W-1:0] chg_new;
	logic                       chg_sat;
	logic [adp_pkg::DATA_W-1:0] chg_mag;
	logic [adp_pkg::DATA_W:0]   par_sum;
	logic [adp_pkg::DATA_W-1:0] par_new;
	logic                       par_sat;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
	assign in_ok    = (32'(in_ch.param_index) < 32'(NUM_PARAMS));
	assign rd_idx   = IW'(idx_q);

	assign in_ch.ready         = (state_q == S_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_index    = out_index_q;
	assign out_ch.param_value  = out_val_q;
	assign out_ch.param_change = out_chg_q;
	assign out_ch.saturated    = out_sat_q;

	// value the addressed parameter takes on restart
	always_comb begin
		if (!in_ok) begin
			restart_val = '0;
		end else if (in_ch.param_index) begin
			restart_val = sp1_q;
		end else begin
			restart_val = sp0_q;
		end
	end

	assign gmag  = g_q[adp_pkg::DATA_W-1] ? (adp_pkg::DATA_W'(0) - g_q) : g_q;
	assign g_pos = !g_q[adp_pkg::DATA_W-1] && (g_q != '0);
	assign w_old = adp_pkg::DATA_W'(decay_q);
	assign w_new = adp_pkg::DATA_W'(17'h1_0000 - {1'b0, decay_q});

	// select multiplier operands by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_GSQ: begin
				mul_a = gmag;
				mul_b = gmag;
			end
			S_EG_OLD: begin
				mul_a = w_old;
				mul_b = avg_g_q[rd_idx];
			end
			S_EG_NEW, S_ED_NEW: begin
				mul_a = w_new;
				mul_b = tmp_q;
			end
			S_SCALE: begin
				mul_a = q_q;
				mul_b = gmag;
			end
			S_PARAM: begin
				mul_a = chg_mag;
				mul_b = chg_mag;
			end
			S_ED_OLD: begin
				mul_a = w_old;
				mul_b = avg_c_q[rd_idx];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		mul_q <= PW'(mul_a) * PW'(mul_b);
	end

	// square: scale down and clip
	assign sq_sh  = mul_q >> FRAC_BITS;
	assign sq_ovf = |sq_sh[PW-1:adp_pkg::DATA_W-1];
	assign sq_val = sq_ovf ? adp_pkg::POS_MAX : sq_sh[adp_pkg::DATA_W-1:0];

	// decaying average: sum of weighted terms, drop 16 fraction bits
	assign avg_sum = acc_q + mul_q;
	assign avg_new = avg_sum[adp_pkg::DATA_W+15:16];

	// averages plus epsilon
	assign num_sum = {1'b0, avg_c_q[rd_idx]} + (adp_pkg::DATA_W+1)'(eps_q);
	assign den_sum = {1'b0, tmp_q} + (adp_pkg::DATA_W+1)'(eps_q);

	// shared compare/subtract unit for divide and root steps
	always_comb begin
		if (state_q == S_ROOT) begin
			sub_a = {rem_q, dsh_q[RW-1:RW-2]};
			sub_b = {q_q, 2'b01};
		end else begin
			sub_a = {1'b0, rem_q, dsh_q[RW-1]};
			sub_b = {2'b00, den_q};
		end
	end
	assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge = !sub_d[XW];

	// quotient with zero-divisor and overflow handling
	always_comb begin
		if (den_q == '0) begin
			ratio     = (num_q != '0) ? adp_pkg::POS_MAX : '0;
			ratio_sat = (num_q != '0);
		end else if (ovf_q || q_q[adp_pkg::DATA_W-1]) begin
			ratio     = adp_pkg::POS_MAX;
			ratio_sat = 1'b1;
		end else begin
			ratio     = q_q;
			ratio_sat = 1'b0;
		end
	end

	// change: scale times gradient magnitude, sign opposite to gradient
	assign dm_sh = mul_q >> FRAC_BITS;
	always_comb begin
		if ((|dm_sh[PW-1:adp_pkg::DATA_W]) ||
			(dm_sh[adp_pkg::DATA_W-1] && (|dm_sh[adp_pkg::DATA_W-2:0]))) begin
			dmag = adp_pkg::MAG_LIM;
		end else begin
			dmag = dm_sh[adp_pkg::DATA_W-1:0];
		end
		chg_sat = 1'b0;
		if (g_pos) begin
			chg_new = adp_pkg::DATA_W'(0) - dmag;
		end else if (dmag[adp_pkg::DATA_W-1]) begin
			chg_new = adp_pkg::POS_MAX;
			chg_sat = 1'b1;
		end else begin
			chg_new = dmag;
		end
	end

	assign chg_mag = chg_q[adp_pkg::DATA_W-1] ? (adp_pkg::DATA_W'(0) - chg_q) : chg_q;

	// new parameter, clipped to the signed range
	always_comb begin
		par_sum = {par_q[rd_idx][adp_pkg::DATA_W-1], par_q[rd_idx]} +
			{chg_q[adp_pkg::DATA_W-1], chg_q};
		par_sat = (par_sum[adp_pkg::DATA_W] != par_sum[adp_pkg::DATA_W-1]);
		if (!par_sat) begin
			par_new = par_sum[adp_pkg::DATA_W-1:0];
		end else if (par_sum[adp_pkg::DATA_W]) begin
			par_new = adp_pkg::NEG_MIN;
		end else begin
			par_new = adp_pkg::POS_MAX;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= adp_pkg::DECAY_RST;
			eps_q   <= adp_pkg::EPS_RST;
			sp0_q   <= '0;
			sp1_q   <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				adp_pkg::REG_DECAY:   decay_q <= cfg_wdata[adp_pkg::CFG_W-1:0];
				adp_pkg::REG_EPSILON: eps_q   <= cfg_wdata[adp_pkg::CFG_W-1:0];
				adp_pkg::REG_START0:  sp0_q   <= cfg_wdata;
				adp_pkg::REG_START1:  sp1_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// parameter and average stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PARAMS; i++) begin
				par_q[i]   <= '0;
				avg_g_q[i] <= '0;
				avg_c_q[i] <= '0;
			end
		end else begin
			if (in_acc && (in_ch.op == adp_pkg::OP_RESTART)) begin
				for (int i = 0; i < NUM_PARAMS; i++) begin
					par_q[i]   <= (i == 0) ? sp0_q : ((i == 1) ? sp1_q : '0);
					avg_g_q[i] <= '0;
					avg_c_q[i] <= '0;
				end
			end
			if (state_q == S_EG_SUM) begin
				avg_g_q[rd_idx] <= avg_new;
			end
			if (state_q == S_PARAM) begin
				par_q[rd_idx] <= par_new;
			end
			if (state_q == S_ED_SUM) begin
				avg_c_q[rd_idx] <= avg_new;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.op == adp_pkg::OP_RESTART || !in_ok) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_GSQ;
						end
					end
				end
				S_GSQ:    state_q <= S_EG_OLD;
				S_EG_OLD: state_q <= S_EG_NEW;
				S_EG_NEW: state_q <= S_EG_SUM;
				S_EG_SUM: state_q <= S_DEN;
				S_DEN: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW - 1)) begin
						state_q <= S_RATIO;
					end
				end
				S_RATIO: begin
					cnt_q   <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(SW - 1)) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE:  state_q <= S_APPLY;
				S_APPLY:  state_q <= S_PARAM;
				S_PARAM:  state_q <= S_ED_OLD;
				S_ED_OLD: state_q <= S_ED_NEW;
				S_ED_NEW: state_q <= S_ED_SUM;
				S_ED_SUM: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					idx_q <= in_ch.param_index;
					g_q   <= in_ch.gradient;
					sat_q <= 1'b0;
					chg_q <= '0;
					if (in_ch.op == adp_pkg::OP_RESTART) begin
						val_q <= restart_val;
					end else begin
						val_q <= '0;
					end
				end
			end
			S_EG_OLD, S_ED_OLD: begin
				tmp_q <= sq_val;
				sat_q <= sat_q | sq_ovf;
			end
			S_EG_NEW, S_ED_NEW: begin
				acc_q <= mul_q;
			end
			S_EG_SUM: begin
				tmp_q <= avg_new;
				if (num_sum[adp_pkg::DATA_W:adp_pkg::DATA_W-1] != 2'b00) begin
					num_q <= adp_pkg::POS_MAX;
					sat_q <= 1'b1;
				end else begin
					num_q <= num_sum[adp_pkg::DATA_W-1:0];
				end
			end
			S_DEN: begin
				if (den_sum[adp_pkg::DATA_W:adp_pkg::DATA_W-1] != 2'b00) begin
					den_q <= adp_pkg::POS_MAX;
					sat_q <= 1'b1;
				end else begin
					den_q <= den_sum[adp_pkg::DATA_W-1:0];
				end
				// load the dividend msb-aligned
				dsh_q <= RW'({num_q[adp_pkg::DATA_W-2:0], {FRAC_BITS{1'b0}}}) << (RW - DW);
				rem_q <= '0;
				q_q   <= '0;
				ovf_q <= 1'b0;
			end
			S_DIV: begin
				// one quotient bit per step
				ovf_q <= ovf_q | q_q[adp_pkg::DATA_W-1];
				q_q   <= {q_q[adp_pkg::DATA_W-2:0], sub_ge};
				rem_q <= sub_ge ? sub_d[adp_pkg::DATA_W-1:0] : sub_a[adp_pkg::DATA_W-1:0];
				dsh_q <= dsh_q << 1;
			end
			S_RATIO: begin
				sat_q <= sat_q | ratio_sat;
				dsh_q <= RW'({ratio[adp_pkg::DATA_W-2:0], {FRAC_BITS{1'b0}}});
				rem_q <= '0;
				q_q   <= '0;
			end
			S_ROOT: begin
				// one root bit per step, two radicand bits consumed
				q_q   <= {q_q[adp_pkg::DATA_W-2:0], sub_ge};
				rem_q <= sub_ge ? sub_d[adp_pkg::DATA_W-1:0] : sub_a[adp_pkg::DATA_W-1:0];
				dsh_q <= dsh_q << 2;
			end
			S_APPLY: begin
				chg_q <= chg_new;
				sat_q <= sat_q | chg_sat;
			end
			S_PARAM: begin
				val_q <= par_new;
				sat_q <= sat_q | par_sat;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= idx_q;
			out_val_q   <= val_q;
			out_chg_q   <= chg_q;
			out_sat_q   <= sat_q;
		end
	end

	// an accepted word always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("accepted word left the sequencer idle");

	// partial remainder stays below a nonzero divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && den_q != '0) |-> (rem_q < den_q))
		else $error("divider remainder reached the divisor");

	// square root of a clipped ratio fits in 30 bits
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCALE) |-> (q_q[adp_pkg::DATA_W-1:adp_pkg::DATA_W-2] == 2'b00))
		else $error("root exceeds its range");

	// decaying averages never leave the positive range
	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EG_SUM || state_q == S_ED_SUM) |-> !avg_new[adp_pkg::DATA_W-1])
		else $error("running average overflowed");

	// results are loaded only after the previous one is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !out_load)
		else $error("pending result overwritten");

endmodule
